// ===== sv/bwof_pkg.sv =====
// Shared types and constants for the box/window overlap fraction core.
package bwof_pkg;

	localparam int COORD_W    = 48;          // Q31.16 coordinate width at the ports
	localparam int CW         = 53;          // internal coordinate width, covers all turn shifts
	localparam int MW         = 50;          // multiplier operand width
	localparam int PW         = 2 * MW;      // product width
	localparam int CNT_W      = 6;           // iteration counter, holds CW
	localparam int FIFO_DEPTH = 2;           // front-to-back queue depth

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CW-1:0]      wcoord_t;
	typedef logic signed [COORD_W:0]   span_t;

	typedef struct packed {
		coord_t north;
		coord_t south;
		coord_t east;
		coord_t west;
		logic   latlong;
	} win_cfg_t;

	typedef struct packed {
		logic   vert_ok;   // vertical overlap is positive
		span_t  v;         // vertical overlap
		span_t  dy;        // box height
		coord_t east;
		coord_t west;
	} box_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_E_CHK,
		ST_W_CHK,
		ST_H1,
		ST_B_CHK,
		ST_C_CHK,
		ST_H2,
		ST_TDIV,
		ST_APPLY,
		ST_MINIT,
		ST_MUL,
		ST_DCHK,
		ST_DIV,
		ST_OUT
	} back_st_t;

	typedef enum logic [1:0] {
		STEP_E,    // pull east edge back under the window
		STEP_W,    // push east edge up to the window west edge
		STEP_B,    // push west edge up to the window
		STEP_C     // pull west edge back under the window east edge
	} turn_step_t;

endpackage

// ===== sv/bwof_front.sv =====
// Front stage: accepts a box, computes vertical overlap and height, queues it.
module bwof_front import bwof_pkg::*; (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [4*COORD_W-1:0]   s_tdata,
	input  win_cfg_t               cfg,
	input  logic                   q_full,
	output logic                   push,
	output box_item_t              item
);

	coord_t bn, bs, nmin, smax;
	span_t  v;

	assign bn = s_tdata[COORD_W-1:0];
	assign bs = s_tdata[2*COORD_W-1:COORD_W];

	assign nmin = (cfg.north < bn) ? cfg.north : bn;
	assign smax = (cfg.south > bs) ? cfg.south : bs;
	assign v    = span_t'(nmin) - span_t'(smax);

	assign s_tready     = !q_full;
	assign push         = s_tvalid && !q_full;
	assign item.v       = v;
	assign item.vert_ok = !v[COORD_W] && (v != '0);
	assign item.dy      = span_t'(bn) - span_t'(bs);
	assign item.east    = s_tdata[3*COORD_W-1:2*COORD_W];
	assign item.west    = s_tdata[4*COORD_W-1:3*COORD_W];

endmodule

// ===== sv/bwof_fifo.sv =====
// Short queue between the front stage and the back sequencer.
module bwof_fifo import bwof_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  box_item_t wdata,
	input  logic      pop,
	output box_item_t rdata,
	output logic      full,
	output logic      not_empty
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	box_item_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_FW-1:0]  cnt_q;

	assign full      = (cnt_q == CNT_FW'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("queue push while full");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FW'(FIFO_DEPTH)) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");

endmodule

// ===== sv/bwof_back.sv =====
// Back sequencer: longitude alignment, overlap width, area products and quotient.
module bwof_back import bwof_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int FRACTION_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  win_cfg_t               cfg,
	input  logic                   in_valid,
	input  box_item_t              item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [FRACTION_BITS:0] result
);

	localparam logic [CW-1:0] TURN = CW'(64'd360 << COORD_FRAC_BITS);
	localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
	localparam logic [CW-1:0] LOW_MASK = (CW'(1) << COORD_FRAC_BITS) - CW'(1);
	localparam logic [13:0] RECIP45 = 14'd11651;   // ceil(2^19 / 45)
	localparam int TDIV_LAST = 4;

	back_st_t   st_q, st_d;
	turn_step_t step_q;

	wcoord_t be_q, bw_q, bwpre_q, h_q;
	logic [MW-1:0]  v_q, dy_q, mpa_q, mpb_q;
	logic [PW-1:0]  mca_q, mcb_q, den_q;
	logic [PW:0]    num_q;
	logic [CW-1:0]  dsh_q, dsav_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FRACTION_BITS:0] q_q, out_q;
	logic out_valid_q;
	logic [14:0] fold_q;
	logic [12:0] sfold_q;
	logic [7:0]  quo_q;

	wcoord_t we_w, ww_w, emin, wmax, piece, hn, width;
	logic [CW-1:0] kturn, ydiv, rem_calc;
	logic [14:0]   csum;
	logic [12:0]   cfold;
	logic [26:0]   qprod;
	logic [5:0]    r45;
	logic [8:0]    r360;
	logic [PW:0]   drem_n;
	logic piece_le0, hn_le0, out_free, div_done;

	assign we_w  = wcoord_t'(cfg.east);
	assign ww_w  = wcoord_t'(cfg.west);
	assign emin  = (we_w < be_q) ? we_w : be_q;
	assign wmax  = (ww_w > bw_q) ? ww_w : bw_q;
	assign piece = emin - wmax;
	assign piece_le0 = piece[CW-1] || (piece == '0);
	assign hn    = (bw_q != bwpre_q) ? h_q + piece : h_q;
	assign hn_le0 = hn[CW-1] || (hn == '0);
	assign width = be_q - bw_q;

	// remainder of the distance by one turn (360 = 8 * 45 degrees): 2^12 is 1 mod 45,
	// so fold the 12-bit chunks of the distance over eight whole degrees, then
	// finish with a small reciprocal step
	assign ydiv  = dsh_q >> (COORD_FRAC_BITS + 3);
	assign csum  = 15'(ydiv[11:0]) + 15'(ydiv[23:12]) + 15'(ydiv[35:24])
		+ 15'(ydiv[47:36]) + 15'(ydiv[CW-1:48]);
	assign cfold = 13'(fold_q[11:0]) + 13'(fold_q[14:12]);
	assign qprod = 27'(sfold_q) * 27'(RECIP45);
	assign r45   = 6'(sfold_q - 13'(quo_q) * 13'd45);
	assign r360  = {r45, dsh_q[COORD_FRAC_BITS +: 3]};
	assign rem_calc = (CW'(r360) << COORD_FRAC_BITS) | (dsh_q & LOW_MASK);
	// whole turns that cover the distance
	assign kturn = dsav_q - rem_q + ((rem_q != '0) ? TURN : '0);
	assign div_done = (cnt_q == CNT_W'(TDIV_LAST));

	assign drem_n = {num_q[PW-1:0], 1'b0};

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign result   = out_q;
	assign pop      = (st_q == ST_IDLE) && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!item.vert_ok)
						st_d = ST_OUT;
					else if (cfg.latlong)
						st_d = ST_E_CHK;
					else
						st_d = ST_H1;
				end
			end
			ST_E_CHK: st_d = (be_q > we_w) ? ST_TDIV : ST_W_CHK;
			ST_W_CHK: st_d = (be_q < ww_w) ? ST_TDIV : ST_H1;
			ST_H1: begin
				if (piece_le0)
					st_d = ST_OUT;
				else if (cfg.latlong)
					st_d = ST_B_CHK;
				else
					st_d = ST_MINIT;
			end
			ST_B_CHK: st_d = (bw_q < ww_w) ? ST_TDIV : ST_C_CHK;
			ST_C_CHK: st_d = (bw_q > we_w) ? ST_TDIV : ST_H2;
			ST_H2:    st_d = hn_le0 ? ST_OUT : ST_MINIT;
			ST_TDIV:  st_d = div_done ? ST_APPLY : ST_TDIV;
			ST_APPLY: begin
				unique case (step_q)
					STEP_E:  st_d = ST_W_CHK;
					STEP_W:  st_d = ST_H1;
					STEP_B:  st_d = ST_C_CHK;
					STEP_C:  st_d = ST_H2;
					default: st_d = ST_H2;
				endcase
			end
			ST_MINIT: st_d = ST_MUL;
			ST_MUL:   st_d = (cnt_q == CNT_W'(MW)) ? ST_DCHK : ST_MUL;
			ST_DCHK:  st_d = (num_q >= {1'b0, den_q}) ? ST_OUT : ST_DIV;
			ST_DIV:   st_d = (cnt_q == CNT_W'(FRACTION_BITS)) ? ST_OUT : ST_DIV;
			ST_OUT:   st_d = out_free ? ST_IDLE : ST_OUT;
			default:  st_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				be_q    <= wcoord_t'(item.east);
				bw_q    <= wcoord_t'(item.west);
				bwpre_q <= wcoord_t'(item.west);
				v_q     <= {1'b0, item.v};
				dy_q    <= {1'b0, item.dy};
				q_q     <= '0;
			end
			ST_E_CHK: begin
				dsh_q  <= be_q - we_w;
				dsav_q <= be_q - we_w;
				rem_q  <= '0;
				cnt_q  <= '0;
				step_q <= STEP_E;
			end
			ST_W_CHK: begin
				dsh_q  <= ww_w - be_q;
				dsav_q <= ww_w - be_q;
				rem_q  <= '0;
				cnt_q  <= '0;
				step_q <= STEP_W;
			end
			ST_H1: h_q <= piece;
			ST_B_CHK: begin
				bwpre_q <= bw_q;
				dsh_q   <= ww_w - bw_q;
				dsav_q  <= ww_w - bw_q;
				rem_q   <= '0;
				cnt_q   <= '0;
				step_q  <= STEP_B;
			end
			ST_C_CHK: begin
				dsh_q  <= bw_q - we_w;
				dsav_q <= bw_q - we_w;
				rem_q  <= '0;
				cnt_q  <= '0;
				step_q <= STEP_C;
			end
			ST_H2: h_q <= hn;
			ST_TDIV: begin
				if (div_done) begin
					dsav_q <= kturn;
				end else begin
					case (cnt_q)
						CNT_W'(0): fold_q  <= csum;
						CNT_W'(1): sfold_q <= cfold;
						CNT_W'(2): quo_q   <= qprod[26:19];
						CNT_W'(3): rem_q   <= rem_calc;
						default: ;
					endcase
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_APPLY: begin
				if (step_q == STEP_E || step_q == STEP_C) begin
					be_q <= be_q - dsav_q;
					bw_q <= bw_q - dsav_q;
				end else begin
					be_q <= be_q + dsav_q;
					bw_q <= bw_q + dsav_q;
				end
			end
			ST_MINIT: begin
				mca_q <= PW'(h_q[MW-1:0]);
				mpa_q <= v_q;
				mcb_q <= PW'(dy_q);
				mpb_q <= width[MW-1:0];
				num_q <= '0;
				den_q <= '0;
				cnt_q <= '0;
			end
			ST_MUL: begin
				if (cnt_q != CNT_W'(MW)) begin
					if (mpa_q[0])
						num_q <= num_q + {1'b0, mca_q};
					if (mpb_q[0])
						den_q <= den_q + mcb_q;
					mca_q <= {mca_q[PW-2:0], 1'b0};
					mcb_q <= {mcb_q[PW-2:0], 1'b0};
					mpa_q <= {1'b0, mpa_q[MW-1:1]};
					mpb_q <= {1'b0, mpb_q[MW-1:1]};
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_DCHK: begin
				cnt_q <= '0;
				if (num_q >= {1'b0, den_q})
					q_q <= ONE;
			end
			ST_DIV: begin
				if (cnt_q != CNT_W'(FRACTION_BITS)) begin
					if (drem_n >= {1'b0, den_q}) begin
						num_q <= drem_n - {1'b0, den_q};
						q_q   <= {q_q[FRACTION_BITS-1:0], 1'b1};
					end else begin
						num_q <= drem_n;
						q_q   <= {q_q[FRACTION_BITS-1:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register: hold result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free)
			out_q <= q_q;
	end

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q <= ONE) else $error("fraction above one");
	a_mul_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_MINIT |-> !h_q[CW-1] && h_q != '0) else $error("nonpositive width");
	a_rem_turn: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_TDIV |-> rem_q < TURN) else $error("turn remainder out of range");

endmodule

// ===== sv/box_window_overlap_fraction_core.sv =====
// Top level of the box/window overlap fraction core: config registers and wiring.
//
//  channel  | dir | width     | contents
//  ---------+-----+-----------+-------------------------------------------------
//  s_*      | in  | 192       | box_north, box_south, box_east, box_west
//  m_*      | out | byte-pad  | overlap_fraction (FRACTION_BITS+1 bits)
//  apb      | in  | 64 / 6    | window edges and lat-long mode, 8 bytes apart
//
// An empty vertical or horizontal overlap skips the area products; otherwise the
// back runs bit-serial area products, then one quotient bit a cycle (no
// division when the fraction saturates), plus the E, W, B and C edge checks in
// lat-long mode and the turn alignments.
// Reset clears the config registers, queue and sequencer; no clearing pass.
// The front takes items while the back works, until the two-entry queue fills;
// the back stalls only while its output register holds an untaken transfer.
module box_window_overlap_fraction_core import bwof_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int FRACTION_BITS   = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// box_north [47:0], box_south [95:48], box_east [143:96], box_west [191:144]
	input  logic [4*COORD_W-1:0]                    s_tdata,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// overlap_fraction [FRACTION_BITS:0], zero fill above
	output logic [((FRACTION_BITS+8)/8)*8-1:0]      m_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [5:0]                              paddr,
	input  logic [63:0]                             pwdata,
	output logic [63:0]                             prdata,
	output logic                                    pready
);

	localparam int OUT_W = ((FRACTION_BITS + 8) / 8) * 8;

	localparam logic [5:0] ADDR_WIN_NORTH = 6'h00;
	localparam logic [5:0] ADDR_WIN_SOUTH = 6'h08;
	localparam logic [5:0] ADDR_WIN_EAST  = 6'h10;
	localparam logic [5:0] ADDR_WIN_WEST  = 6'h18;
	localparam logic [5:0] ADDR_LATLONG   = 6'h20;

	coord_t    win_north_q, win_south_q, win_east_q, win_west_q;
	logic      latlong_q;
	win_cfg_t  cfg;
	logic      wr_en;

	box_item_t front_item, back_item;
	logic      push, pop, q_full, q_valid;
	logic [FRACTION_BITS:0] result;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Config writes must land only while the core is idle (the block does not enforce this), so the back reads them live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_north_q <= '0;
			win_south_q <= '0;
			win_east_q  <= '0;
			win_west_q  <= '0;
			latlong_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr)
				ADDR_WIN_NORTH: win_north_q <= pwdata[COORD_W-1:0];
				ADDR_WIN_SOUTH: win_south_q <= pwdata[COORD_W-1:0];
				ADDR_WIN_EAST:  win_east_q  <= pwdata[COORD_W-1:0];
				ADDR_WIN_WEST:  win_west_q  <= pwdata[COORD_W-1:0];
				ADDR_LATLONG:   latlong_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back with sign extension of the edges.
	always_comb begin
		unique case (paddr)
			ADDR_WIN_NORTH: prdata = 64'(win_north_q);
			ADDR_WIN_SOUTH: prdata = 64'(win_south_q);
			ADDR_WIN_EAST:  prdata = 64'(win_east_q);
			ADDR_WIN_WEST:  prdata = 64'(win_west_q);
			ADDR_LATLONG:   prdata = 64'(latlong_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.north   = win_north_q;
	assign cfg.south   = win_south_q;
	assign cfg.east    = win_east_q;
	assign cfg.west    = win_west_q;
	assign cfg.latlong = latlong_q;

	// Front: accept a transfer, clip vertically, queue it.
	bwof_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.item     (front_item)
	);

	bwof_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (front_item),
		.pop       (pop),
		.rdata     (back_item),
		.full      (q_full),
		.not_empty (q_valid)
	);

	// Back: align longitudes, sum horizontal overlap, divide areas.
	bwof_back #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.FRACTION_BITS   (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (q_valid),
		.item     (back_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result   (result)
	);

	assign m_tdata = OUT_W'(result);

endmodule
